// ===== design/skm_pkg.sv =====
// Shared types and constants for the substring keyword match block.
// No dependencies.
package skm_pkg;

  localparam int MaxKeyword = 64;
  localparam int LenW       = $clog2(MaxKeyword + 1);
  localparam int IdxW       = (MaxKeyword > 1) ? $clog2(MaxKeyword) : 1;
  localparam int ByteW      = 8;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_KEY   = 2'd1,
    CMD_TITLE = 2'd2,
    CMD_END   = 2'd3
  } cmd_e;

  // One item leaving the input register toward the match core.
  typedef struct packed {
    logic             fire;
    cmd_e             cmd;
    logic [ByteW-1:0] data;
  } beat_t;

endpackage

// ===== design/skm_in_stage.sv =====
// Input register stage: holds one accepted beat and releases it to the core.
// Depends on skm_pkg.
module skm_in_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               cmd_i,
  input  logic [skm_pkg::ByteW-1:0] data_byte_i,
  input  logic                     out_busy_i,
  output skm_pkg::beat_t           beat_o
);
  import skm_pkg::*;

  logic             valid_q;
  logic             valid_d;
  cmd_e             cmd_q;
  logic [ByteW-1:0] data_q;
  logic             advance;

  // An end-of-title beat needs a free result slot; all others always advance.
  assign advance    = valid_q && ((cmd_q != CMD_END) || !out_busy_i);
  assign in_ready_o = !valid_q || advance;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q  <= cmd_e'(cmd_i);
      data_q <= data_byte_i;
    end
  end

  assign beat_o.fire = advance;
  assign beat_o.cmd  = cmd_q;
  assign beat_o.data = data_q;

endmodule

// ===== design/skm_match_core.sv =====
// Keyword store, parallel byte compare and partial-match vector.
// Depends on skm_pkg.
module skm_match_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  skm_pkg::beat_t beat_i,
  output logic           found_o
);
  import skm_pkg::*;

  logic [ByteW-1:0]      kw_store_q [MaxKeyword];
  logic [LenW-1:0]       kw_len_q, kw_len_d;
  logic                  overflow_q, overflow_d;
  logic [MaxKeyword-1:0] pm_q, pm_d;
  logic                  seen_q, seen_d;

  logic [MaxKeyword-1:0] eq;
  logic [MaxKeyword-1:0] pm_next;
  logic [LenW-1:0]       len_m1;
  logic                  has_room;
  logic                  hit;

  assign has_room = (kw_len_q < LenW'(MaxKeyword));
  assign len_m1   = kw_len_q - LenW'(1);

  // Per-lane compare; lanes past the keyword length never match.
  always_comb begin
    for (int j = 0; j < MaxKeyword; j++) begin
      eq[j] = (kw_store_q[j] == beat_i.data) && (LenW'(j) < kw_len_q);
    end
  end

  assign pm_next = {pm_q[MaxKeyword-2:0], 1'b1} & eq;
  assign hit     = (kw_len_q != '0) && pm_next[len_m1[IdxW-1:0]];

  always_comb begin
    if (overflow_q) begin
      found_o = 1'b0;
    end else if (kw_len_q == '0) begin
      found_o = 1'b1;
    end else begin
      found_o = seen_q;
    end
  end

  always_comb begin
    kw_len_d   = kw_len_q;
    overflow_d = overflow_q;
    pm_d       = pm_q;
    seen_d     = seen_q;
    if (beat_i.fire) begin
      case (beat_i.cmd)
        CMD_START: begin
          kw_len_d   = '0;
          overflow_d = 1'b0;
          pm_d       = '0;
          seen_d     = 1'b0;
        end
        CMD_KEY: begin
          if (has_room) begin
            kw_len_d = kw_len_q + LenW'(1);
          end else begin
            overflow_d = 1'b1;
          end
          pm_d   = '0;
          seen_d = 1'b0;
        end
        CMD_TITLE: begin
          pm_d   = pm_next;
          seen_d = seen_q | hit;
        end
        default: begin
          pm_d   = '0;
          seen_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_len_q   <= '0;
      overflow_q <= 1'b0;
      pm_q       <= '0;
      seen_q     <= 1'b0;
    end else begin
      kw_len_q   <= kw_len_d;
      overflow_q <= overflow_d;
      pm_q       <= pm_d;
      seen_q     <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i.fire && (beat_i.cmd == CMD_KEY) && has_room) begin
      kw_store_q[kw_len_q[IdxW-1:0]] <= beat_i.data;
    end
  end

endmodule

// ===== design/substring_keyword_match.sv =====
// Top level of the substring keyword match block: input stage, match core,
// result register. Depends on skm_pkg, skm_in_stage, skm_match_core.
//
//   channel | handshake                  | payload
//   --------+----------------------------+--------------------------
//   in      | in_valid_i / in_ready_o    | cmd_i[1:0], data_byte_i[7:0]
//   out     | out_valid_o / out_ready_i  | found_o
//
// One beat per cycle sustained. A beat sits in the input register,
// where the 64 lane compare and partial-match update run; an end-of-title
// beat then loads the result register, which drives found_o. Input readiness
// only drops when an end-of-title beat waits behind an untaken result. Reset
// clears the keyword length, overflow mark and match state at once; the store
// is never read past the loaded length.
module substring_keyword_match (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                cmd_i,
  input  logic [skm_pkg::ByteW-1:0] data_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      found_o
);
  import skm_pkg::*;

  beat_t beat;
  logic  core_found;
  logic  out_valid_q, out_valid_d;
  logic  found_q;
  logic  out_busy;
  logic  load_result;

  // Result slot is busy while it holds a result that is not taken this cycle.
  assign out_busy    = out_valid_q && !out_ready_i;
  assign load_result = beat.fire && (beat.cmd == CMD_END);

  skm_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .out_busy_i  (out_busy),
    .beat_o      (beat)
  );

  skm_match_core u_match_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .found_o (core_found)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      found_q <= core_found;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;

endmodule

// ===== tb/skm_checker.sv =====
// Checker for substring_keyword_match: follows the in and out channels, keeps its
// own copy of keyword and partial-match state, compares every found beat.
// Depends on skm_pkg.
module skm_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [1:0]                cmd_i,
  input  logic [skm_pkg::ByteW-1:0] data_byte_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      found_i,
  output int                        errors_o,
  output int                        waiting_o,
  output int                        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import skm_pkg::*;

  logic [ByteW-1:0]      kw_mem [MaxKeyword];
  logic [LenW-1:0]       kw_len;
  logic                  kw_over;
  logic [MaxKeyword-1:0] partial;
  logic                  seen;
  logic                  found_pending [$];
  logic                  want;
  int                    errors;
  int                    checked;

  // Advance the match state by one accepted beat; an end beat queues its verdict.
  task automatic track_match(input cmd_e c, input logic [ByteW-1:0] b);
    logic [MaxKeyword-1:0] hits;
    hits = '0;
    case (c)
      CMD_START: begin
        kw_len  = '0;
        kw_over = 1'b0;
        partial = '0;
        seen    = 1'b0;
      end
      CMD_KEY: begin
        if (kw_len < MaxKeyword) begin
          kw_mem[kw_len[IdxW-1:0]] = b;
          kw_len = kw_len + 1'b1;
        end else begin
          kw_over = 1'b1;
        end
        partial = '0;
        seen    = 1'b0;
      end
      CMD_TITLE: begin
        for (int j = 0; j < MaxKeyword; j++) begin
          if (j < kw_len && kw_mem[j] == b) hits[j] = 1'b1;
        end
        partial = {partial[MaxKeyword-2:0], 1'b1} & hits;
        if (kw_len != 0 && partial[kw_len - 1'b1]) seen = 1'b1;
      end
      default: begin
        found_pending.push_back(kw_over ? 1'b0 : (kw_len == 0) ? 1'b1 : seen);
        partial = '0;
        seen    = 1'b0;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_len  = '0;
      kw_over = 1'b0;
      partial = '0;
      seen    = 1'b0;
      errors  = 0;
      checked = 0;
      found_pending.delete();
    end else begin
      // Result side first: a beat taken this edge can't be answered this edge.
      if (out_valid_i && out_ready_i) begin
        if (found_pending.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result beat with none outstanding, found=%0b",
                                     $time, found_i);
        end else begin
          want = found_pending.pop_front();
          checked++;
          if (found_i !== want) begin
            errors++;
            if (errors <= 10) $display("%0t: found mismatch, expected %0b, got %0b",
                                       $time, want, found_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) track_match(cmd_e'(cmd_i), data_byte_i);
    end
    errors_o  <= errors;
    waiting_o <= found_pending.size();
    checked_o <= checked;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for substring_keyword_match: clock, reset, beat stimulus and
// verdict. Depends on skm_pkg, skm_checker and the block itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import skm_pkg::*;

  // Stop generating sequences once this many beats have gone in.
  localparam int NumBeats = 1150;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [1:0]       cmd_i       = CMD_START;
  logic [ByteW-1:0] data_byte_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             found_o;

  int errors;
  int waiting;
  int checked;

  // Idle rates in percent, changed per phase.
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;

  int beats_sent        = 0;
  int keywords_loaded   = 0;
  int keywords_overflow = 0;

  // Keyword as the stimulus side knows it (store-sized), plus a small
  // per-keyword alphabet so titles hit partial matches often.
  logic [ByteW-1:0] cur_kw [$];
  logic [ByteW-1:0] alph [3];

  substring_keyword_match dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_o     (found_o)
  );

  skm_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_i     (found_o),
    .errors_o    (errors),
    .waiting_o   (waiting),
    .checked_o   (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random backpressure at the current stall rate.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Drive one beat and hold it until taken. Gaps are inserted up front, so
  // valid is never dropped and raised in the same step.
  task automatic send_beat(input cmd_e c, input logic [ByteW-1:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  // Mostly alphabet bytes, sometimes any byte.
  function automatic logic [ByteW-1:0] pick_byte();
    if ($urandom_range(9) < 7) return alph[$urandom_range(2)];
    return 8'($urandom_range(255));
  endfunction

  // Start a keyword of n bytes; more than the store holds sets overflow.
  task automatic load_keyword(input int n);
    logic [ByteW-1:0] b;
    for (int i = 0; i < 3; i++) alph[i] = 8'($urandom_range(255));
    send_beat(CMD_START, 8'($urandom_range(255)));
    cur_kw.delete();
    keywords_loaded++;
    if (n > MaxKeyword) keywords_overflow++;
    for (int i = 0; i < n; i++) begin
      b = pick_byte();
      send_beat(CMD_KEY, b);
      if (cur_kw.size() < MaxKeyword) cur_kw.push_back(b);
    end
  endtask

  // One title: random lead-in and tail around the keyword, a prefix of it,
  // a copy with one byte damaged, or nothing. Now and then a keyword byte
  // lands after the lead-in, which abandons the title in progress.
  task automatic send_title();
    int               pre;
    int               post;
    int               mode;
    int               len;
    int               flip;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] mask;
    pre  = $urandom_range(4);
    post = $urandom_range(4);
    mode = $urandom_range(9);
    mask = 8'($urandom_range(1, 255));
    repeat (pre) send_beat(CMD_TITLE, pick_byte());
    if (mode == 9) begin
      b = pick_byte();
      send_beat(CMD_KEY, b);
      if (cur_kw.size() < MaxKeyword) cur_kw.push_back(b);
    end
    len  = (mode == 6 || mode == 7) ? $urandom_range(cur_kw.size()) :
           (mode == 8) ? 0 : cur_kw.size();
    flip = (mode == 5 && cur_kw.size() > 0) ? $urandom_range(cur_kw.size() - 1) : -1;
    for (int i = 0; i < len; i++) begin
      send_beat(CMD_TITLE, (i == flip) ? (cur_kw[i] ^ mask) : cur_kw[i]);
    end
    repeat (post) send_beat(CMD_TITLE, pick_byte());
    send_beat(CMD_END, 8'($urandom_range(255)));
  endtask

  // Four idling phases rotate every hundred beats: none, sender gaps,
  // receiver stalls, then both at a lighter rate.
  task automatic pick_phase();
    case ((beats_sent / 100) % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
      default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
    endcase
  endtask

  initial begin
    int r;
    int n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling.
    // Empty keyword straight out of reset: an empty title matches.
    send_beat(CMD_END, 8'h00);
    // Empty keyword, title with extreme bytes: matches.
    send_beat(CMD_TITLE, 8'h00);
    send_beat(CMD_TITLE, 8'hFF);
    send_beat(CMD_END, 8'hFF);
    // Keyword 00 FF; title FF 00 FF holds it.
    send_beat(CMD_START, 8'hFF);
    send_beat(CMD_KEY, 8'h00);
    send_beat(CMD_KEY, 8'hFF);
    send_beat(CMD_TITLE, 8'hFF);
    send_beat(CMD_TITLE, 8'h00);
    send_beat(CMD_TITLE, 8'hFF);
    send_beat(CMD_END, 8'h00);
    // Title shorter than the keyword: no match.
    send_beat(CMD_TITLE, 8'h00);
    send_beat(CMD_END, 8'h00);
    // Keyword grows mid-title to 00 FF 41; the started title is dropped.
    send_beat(CMD_TITLE, 8'h00);
    send_beat(CMD_KEY, 8'h41);
    send_beat(CMD_TITLE, 8'h00);
    send_beat(CMD_TITLE, 8'hFF);
    send_beat(CMD_TITLE, 8'h41);
    send_beat(CMD_END, 8'h00);
    // Empty title against a real keyword: no match.
    send_beat(CMD_END, 8'h5A);
    // Start back to an empty keyword; data on start and end is ignored.
    send_beat(CMD_START, 8'hA5);
    send_beat(CMD_END, 8'h5A);

    // Random part: mostly keyword-then-titles sequences, some raw noise.
    // Long keywords (just under to just past the store size) are kept rare.
    while (beats_sent < NumBeats) begin
      pick_phase();
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_beat(cmd_e'($urandom_range(3)), 8'($urandom_range(255)));
        end
        // Noise may have touched the keyword; resync with a fresh one.
        load_keyword($urandom_range(0, 4));
      end else begin
        r = $urandom_range(99);
        n = (r < 8)  ? 0 :
            (r < 70) ? $urandom_range(1, 5) :
            (r < 95) ? $urandom_range(6, 20) :
                       $urandom_range(MaxKeyword - 1, MaxKeyword + 2);
        load_keyword(n);
        repeat ($urandom_range(1, 4)) send_title();
      end
    end
    in_valid_i <= 1'b0;

    // Drain: let the checker see every outstanding result, then let anything
    // stray show up before the verdict.
    @(posedge clk_i);
    wait (waiting == 0);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d input beats and %0d checked results over %0d keywords,",
             beats_sent, checked, keywords_loaded);
    $display("%0d of them past the store size, with all four idling phases.",
             keywords_overflow);
    if (errors == 0 && waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", waiting);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
